>>> sv/jd2cd_pkg.sv
// jd2cd_pkg: shared constants and small tables for the day-number to calendar
// date converter. No dependencies; used by the top level and its testbench.
`default_nettype none

package jd2cd_pkg;

   // field widths
   localparam int unsigned DAY_NUMBER_BITS = 23;
   localparam int unsigned SOD_BITS        = 17;
   localparam int unsigned YEAR_BITS       = 16;
   localparam int unsigned MONTH_BITS      = 4;
   localparam int unsigned DAY_BITS        = 5;
   localparam int unsigned HOUR_BITS       = 5;
   localparam int unsigned MINUTE_BITS     = 6;
   localparam int unsigned SECOND_BITS     = 6;

   // calendar constants, all scaled to integers
   localparam int unsigned GREGORIAN_START = 2299161;
   localparam int unsigned ALFA_BIAS       = 7468865;
   localparam int unsigned ALFA_DIV        = 146097;
   localparam int unsigned B_OFFSET        = 1524;
   localparam int unsigned C_SCALE         = 20;
   localparam int unsigned C_BIAS          = 2442;
   localparam int unsigned C_DIV           = 7305;
   localparam int unsigned D_MUL           = 1461;
   localparam int unsigned YEAR_BASE       = 4716;
   localparam int unsigned MONTH_SPLIT_E   = 14;
   localparam int unsigned LAST_WINTER_MON = 2;

   // time of day
   localparam int unsigned SECONDS_PER_DAY    = 86400;
   localparam int unsigned SECONDS_PER_HOUR   = 3600;
   localparam int unsigned SECONDS_PER_MINUTE = 60;
   localparam int unsigned HOUR_REM_BITS      = $clog2(SECONDS_PER_HOUR);
   localparam int unsigned HOUR_Q_BITS        = SOD_BITS - HOUR_REM_BITS + 1;
   localparam int unsigned MIN_REM_BITS       = $clog2(SECONDS_PER_MINUTE);
   localparam int unsigned MIN_Q_BITS         = HOUR_REM_BITS - MIN_REM_BITS + 1;

   // b - d is always within 123..488, so e lands in 4..15
   localparam int unsigned BD_BITS = 9;
   localparam int unsigned E_BITS  = 4;
   localparam int unsigned E_MIN   = 4;
   localparam int unsigned E_STEPS = 11;

   // smallest b - d for which e reaches 5, 6, ... 15: ceil(30.6001 * e)
   localparam logic [BD_BITS-1:0] E_THRESH [E_STEPS] = '{
      9'd154, 9'd184, 9'd215, 9'd245, 9'd276, 9'd307,
      9'd337, 9'd368, 9'd398, 9'd429, 9'd460
   };

   // e from b - d; thresholds rise, so e is the base plus the count of hits
   function automatic logic [E_BITS-1:0] jd2cd_e_index(input logic [BD_BITS-1:0] bd);
      logic [E_STEPS-1:0] hits;
      for (int k = 0; k < E_STEPS; k++) begin
         hits[k] = (bd >= E_THRESH[k]);
      end
      return E_BITS'(E_MIN) + E_BITS'($countones(hits));
   endfunction

   // floor(30.6001 * e), days before the month within the march-based year
   function automatic logic [BD_BITS-1:0] jd2cd_month_offset(input logic [E_BITS-1:0] e);
      logic [BD_BITS-1:0] off;
      unique case (e)
         4'd4:    off = 9'd122;
         4'd5:    off = 9'd153;
         4'd6:    off = 9'd183;
         4'd7:    off = 9'd214;
         4'd8:    off = 9'd244;
         4'd9:    off = 9'd275;
         4'd10:   off = 9'd306;
         4'd11:   off = 9'd336;
         4'd12:   off = 9'd367;
         4'd13:   off = 9'd397;
         4'd14:   off = 9'd428;
         4'd15:   off = 9'd459;
         default: off = 9'd0;
      endcase
      return off;
   endfunction

endpackage

`default_nettype wire

>>> sv/jd2cd_cdiv.sv
// jd2cd_cdiv: pipelined unsigned division by a constant (reciprocal multiply,
// one correction step). Three register stages. Standalone, no package needed.
`default_nettype none

module jd2cd_cdiv #(
   parameter  int unsigned NUM_BITS  = 24,
   parameter  int unsigned DIVISOR   = 146097,
   localparam int unsigned REM_BITS  = $clog2(DIVISOR),
   localparam int unsigned QUOT_BITS = NUM_BITS - REM_BITS + 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [NUM_BITS-1:0]  in_num,
   output logic                      out_valid,
   output logic [QUOT_BITS-1:0]      out_quot,
   output logic [REM_BITS-1:0]       out_rem
);

   localparam int unsigned PROD_BITS = NUM_BITS + QUOT_BITS;
   // floor(2^N / D) underestimates the quotient by at most one
   localparam logic [QUOT_BITS-1:0] RECIP =
      QUOT_BITS'((64'd1 << NUM_BITS) / 64'(DIVISOR));
   localparam logic [NUM_BITS-1:0]  DIV_N = NUM_BITS'(DIVISOR);
   localparam logic [REM_BITS:0]    DIV_R = (REM_BITS+1)'(DIVISOR);

   logic                  valid1_ff, valid2_ff, valid3_ff;
   logic [NUM_BITS-1:0]   num1_ff;
   logic [PROD_BITS-1:0]  prod1_ff, prod1_in;
   logic [QUOT_BITS-1:0]  qest2_ff, qest2_in;
   logic [REM_BITS:0]     rem2_ff, rem2_in;
   logic [NUM_BITS-1:0]   back2;
   logic [NUM_BITS-1:0]   diff2;
   logic [QUOT_BITS-1:0]  quot3_ff, quot3_in;
   logic [REM_BITS-1:0]   rem3_ff, rem3_in;
   logic                  fix3;

   always_comb begin
      prod1_in = PROD_BITS'(in_num) * PROD_BITS'(RECIP);
      qest2_in = prod1_ff[PROD_BITS-1 -: QUOT_BITS];
      back2    = NUM_BITS'(NUM_BITS'(qest2_in) * DIV_N);
      diff2    = num1_ff - back2;
      rem2_in  = diff2[REM_BITS:0];
      fix3     = (rem2_ff >= DIV_R);
      quot3_in = qest2_ff + QUOT_BITS'(fix3);
      rem3_in  = fix3 ? REM_BITS'(rem2_ff - DIV_R) : rem2_ff[REM_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      num1_ff  <= in_num;
      prod1_ff <= prod1_in;
      qest2_ff <= qest2_in;
      rem2_ff  <= rem2_in;
      quot3_ff <= quot3_in;
      rem3_ff  <= rem3_in;
   end

   assign out_valid = valid3_ff;
   assign out_quot  = quot3_ff;
   assign out_rem   = rem3_ff;

   // corrected remainder is always below the divisor
   assert property (@(posedge clock) disable iff (reset)
      valid3_ff |-> (rem3_ff < DIV_R[REM_BITS-1:0] || DIV_R[REM_BITS]))
      else $error("cdiv: remainder not below divisor");

   assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##3 out_valid)
      else $error("cdiv: beat lost in divider pipeline");

endmodule

`default_nettype wire

>>> sv/julian_day_to_calendar_date_top.sv
// julian_day_to_calendar_date_top: day number and second of day to calendar
// date and time. Uses jd2cd_pkg and four jd2cd_cdiv constant dividers.
// Throughput one beat per cycle while busy is low, that is outside reset.
// The rate is set by the pipeline itself: every stage is registered and busy
// stays low, so a new beat may enter on every clock.
// Synchronous reset clears all valid bits; busy is high only while in reset.
// No memories, so there is no clearing pass after reset.
`default_nettype none

module julian_day_to_calendar_date_top #(
   parameter int unsigned DAY_NUMBER_BITS = jd2cd_pkg::DAY_NUMBER_BITS
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [DAY_NUMBER_BITS-1:0]            req_day_number,
   input  wire logic [jd2cd_pkg::SOD_BITS-1:0]        req_second_of_day,
   output logic                                       rsp_valid,
   output logic signed [jd2cd_pkg::YEAR_BITS-1:0]     rsp_year,
   output logic [jd2cd_pkg::MONTH_BITS-1:0]           rsp_month,
   output logic [jd2cd_pkg::DAY_BITS-1:0]             rsp_day,
   output logic [jd2cd_pkg::HOUR_BITS-1:0]            rsp_hour,
   output logic [jd2cd_pkg::MINUTE_BITS-1:0]          rsp_minute,
   output logic [jd2cd_pkg::SECOND_BITS-1:0]          rsp_second
);

   localparam int unsigned W           = DAY_NUMBER_BITS;
   localparam int unsigned NA_BITS     = W + 2;
   localparam int unsigned ALFA_BITS   = NA_BITS - $clog2(jd2cd_pkg::ALFA_DIV) + 1;
   localparam int unsigned B_BITS      = W + 1;
   localparam int unsigned N2_BITS     = W + 6;
   localparam int unsigned C_BITS      = N2_BITS - $clog2(jd2cd_pkg::C_DIV) + 1;
   localparam int unsigned D_PROD_BITS = C_BITS + $clog2(jd2cd_pkg::D_MUL);
   localparam int unsigned D_BITS      = D_PROD_BITS - 2;
   localparam int unsigned Y_BITS      = C_BITS + 1;
   localparam int unsigned SOD_BITS    = jd2cd_pkg::SOD_BITS;
   localparam int unsigned TIME_BITS   = jd2cd_pkg::HOUR_BITS + jd2cd_pkg::MINUTE_BITS
                                         + jd2cd_pkg::SECOND_BITS;
   localparam int unsigned DIV_STAGES  = 3;
   localparam int unsigned TIME_DELAY  = 5;
   localparam int unsigned LATENCY     = 13;
   localparam int unsigned BD_BITS     = jd2cd_pkg::BD_BITS;
   localparam int unsigned E_BITS      = jd2cd_pkg::E_BITS;

   logic accept;

   // stage 1
   logic                 v1_ff;
   logic [W-1:0]         z1_ff;
   logic                 greg1_ff, greg1_in;
   logic [NA_BITS-1:0]   n1_ff, n1_in;
   logic [SOD_BITS-1:0]  s1_ff, s1_in;

   // alfa divider, stages 2..4
   logic                 alfa_valid;
   logic [ALFA_BITS-1:0] alfa_q;
   logic [W:0]           zg_ff [DIV_STAGES];

   // stages 5 and 6
   logic                 v5_ff, v6_ff;
   logic [B_BITS-1:0]    b5_ff, b5_in, b6_ff, a5;
   logic [N2_BITS-1:0]   n2_ff, n2_in;

   // c divider, stages 7..9
   logic                 c_valid;
   logic [C_BITS-1:0]    c_q;
   logic [B_BITS-1:0]    bdly_ff [DIV_STAGES];

   // stages 10..12
   logic                 v10_ff, v11_ff, v12_ff;
   logic [B_BITS-1:0]    b10_ff;
   logic [C_BITS-1:0]    c10_ff, c11_ff, c12_ff;
   logic [D_PROD_BITS-1:0] dprod10;
   logic [D_BITS-1:0]    d10_ff, d10_in;
   logic [B_BITS-1:0]    bdiff11;
   logic [BD_BITS-1:0]   bd11_ff, bd11_in, bd12_ff;
   logic [E_BITS-1:0]    e12_ff, e12_in;

   // stage 13, output registers
   logic                 rsp_valid_ff;
   logic [jd2cd_pkg::YEAR_BITS-1:0]  year13_ff, year13_in;
   logic [jd2cd_pkg::MONTH_BITS-1:0] month13_ff, month13_in;
   logic [jd2cd_pkg::DAY_BITS-1:0]   day13_ff, day13_in;
   logic [TIME_BITS-1:0]             time13_ff;
   logic [E_BITS-1:0]                mon13;
   logic [Y_BITS-1:0]                ywide13;
   logic [BD_BITS-1:0]               dom13;

   // time path
   logic                                   hr_valid, mn_valid;
   logic [jd2cd_pkg::HOUR_Q_BITS-1:0]      hr_q;
   logic [jd2cd_pkg::HOUR_REM_BITS-1:0]    hr_rem;
   logic [jd2cd_pkg::MIN_Q_BITS-1:0]       mn_q;
   logic [jd2cd_pkg::MIN_REM_BITS-1:0]     mn_rem;
   logic [jd2cd_pkg::HOUR_BITS-1:0]        hdly_ff [DIV_STAGES];
   logic [TIME_BITS-1:0]                   tm_ff [TIME_DELAY];
   logic                                   tv_ff [TIME_DELAY];
   logic [TIME_BITS-1:0]                   tm7;

   assign busy   = reset;
   assign accept = start & ~busy;

   // ---------------------------------------------------------------- stage 1
   always_comb begin
      greg1_in = (req_day_number >= W'(jd2cd_pkg::GREGORIAN_START));
      n1_in    = greg1_in ? ({req_day_number, 2'b00} - NA_BITS'(jd2cd_pkg::ALFA_BIAS))
                          : '0;
      // seconds past the end of the day saturate to 23:59:59
      s1_in    = (req_second_of_day >= SOD_BITS'(jd2cd_pkg::SECONDS_PER_DAY))
                 ? SOD_BITS'(jd2cd_pkg::SECONDS_PER_DAY - 1) : req_second_of_day;
   end

   always_ff @(posedge clock) begin
      z1_ff    <= req_day_number;
      greg1_ff <= greg1_in;
      n1_ff    <= n1_in;
      s1_ff    <= s1_in;
   end

   // ---------------------------------------------------------- alfa division
   jd2cd_cdiv #(
      .NUM_BITS (NA_BITS),
      .DIVISOR  (jd2cd_pkg::ALFA_DIV)
   ) u_alfa_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v1_ff),
      .in_num    (n1_ff),
      .out_valid (alfa_valid),
      .out_quot  (alfa_q),
      .out_rem   ()
   );

   always_ff @(posedge clock) begin
      zg_ff[0] <= {greg1_ff, z1_ff};
      for (int i = 1; i < DIV_STAGES; i++) begin
         zg_ff[i] <= zg_ff[i-1];
      end
   end

   // ------------------------------------------------------- stages 5 and 6
   always_comb begin
      a5    = zg_ff[DIV_STAGES-1][W]
              ? (B_BITS'(zg_ff[DIV_STAGES-1][W-1:0]) + B_BITS'(1) + B_BITS'(alfa_q)
                 - B_BITS'(alfa_q >> 2))
              : B_BITS'(zg_ff[DIV_STAGES-1][W-1:0]);
      b5_in = a5 + B_BITS'(jd2cd_pkg::B_OFFSET);
      n2_in = N2_BITS'(b5_ff) * N2_BITS'(jd2cd_pkg::C_SCALE) - N2_BITS'(jd2cd_pkg::C_BIAS);
   end

   always_ff @(posedge clock) begin
      b5_ff <= b5_in;
      b6_ff <= b5_ff;
      n2_ff <= n2_in;
   end

   // ------------------------------------------------------------- c division
   jd2cd_cdiv #(
      .NUM_BITS (N2_BITS),
      .DIVISOR  (jd2cd_pkg::C_DIV)
   ) u_c_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v6_ff),
      .in_num    (n2_ff),
      .out_valid (c_valid),
      .out_quot  (c_q),
      .out_rem   ()
   );

   always_ff @(posedge clock) begin
      bdly_ff[0] <= b6_ff;
      for (int i = 1; i < DIV_STAGES; i++) begin
         bdly_ff[i] <= bdly_ff[i-1];
      end
   end

   // --------------------------------------------------------- stages 10..12
   always_comb begin
      dprod10 = D_PROD_BITS'(c_q) * D_PROD_BITS'(jd2cd_pkg::D_MUL);
      d10_in  = dprod10[D_PROD_BITS-1:2];
      // b - d stays small, the low bits carry the whole value
      bdiff11 = b10_ff - B_BITS'(d10_ff);
      bd11_in = bdiff11[BD_BITS-1:0];
      e12_in  = jd2cd_pkg::jd2cd_e_index(bd11_ff);
   end

   always_ff @(posedge clock) begin
      b10_ff  <= bdly_ff[DIV_STAGES-1];
      c10_ff  <= c_q;
      d10_ff  <= d10_in;
      c11_ff  <= c10_ff;
      bd11_ff <= bd11_in;
      c12_ff  <= c11_ff;
      bd12_ff <= bd11_ff;
      e12_ff  <= e12_in;
   end

   // --------------------------------------------------------------- stage 13
   always_comb begin
      mon13      = (e12_ff < E_BITS'(jd2cd_pkg::MONTH_SPLIT_E))
                   ? (e12_ff - E_BITS'(1)) : (e12_ff - E_BITS'(13));
      ywide13    = Y_BITS'(c12_ff)
                   - ((mon13 > E_BITS'(jd2cd_pkg::LAST_WINTER_MON))
                      ? Y_BITS'(jd2cd_pkg::YEAR_BASE) : Y_BITS'(jd2cd_pkg::YEAR_BASE - 1));
      dom13      = bd12_ff - jd2cd_pkg::jd2cd_month_offset(e12_ff);
      month13_in = mon13;
      year13_in  = ywide13[jd2cd_pkg::YEAR_BITS-1:0];
      day13_in   = dom13[jd2cd_pkg::DAY_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      year13_ff  <= year13_in;
      month13_ff <= month13_in;
      day13_ff   <= day13_in;
      time13_ff  <= tm_ff[TIME_DELAY-1];
   end

   // -------------------------------------------------------------- time path
   jd2cd_cdiv #(
      .NUM_BITS (SOD_BITS),
      .DIVISOR  (jd2cd_pkg::SECONDS_PER_HOUR)
   ) u_hour_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v1_ff),
      .in_num    (s1_ff),
      .out_valid (hr_valid),
      .out_quot  (hr_q),
      .out_rem   (hr_rem)
   );

   jd2cd_cdiv #(
      .NUM_BITS (jd2cd_pkg::HOUR_REM_BITS),
      .DIVISOR  (jd2cd_pkg::SECONDS_PER_MINUTE)
   ) u_minute_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hr_valid),
      .in_num    (hr_rem),
      .out_valid (mn_valid),
      .out_quot  (mn_q),
      .out_rem   (mn_rem)
   );

   assign tm7 = {hdly_ff[DIV_STAGES-1], jd2cd_pkg::MINUTE_BITS'(mn_q), mn_rem};

   always_ff @(posedge clock) begin
      hdly_ff[0] <= jd2cd_pkg::HOUR_BITS'(hr_q);
      for (int i = 1; i < DIV_STAGES; i++) begin
         hdly_ff[i] <= hdly_ff[i-1];
      end
      tm_ff[0] <= tm7;
      for (int i = 1; i < TIME_DELAY; i++) begin
         tm_ff[i] <= tm_ff[i-1];
      end
   end

   // ------------------------------------------------------------ valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v10_ff       <= 1'b0;
         v11_ff       <= 1'b0;
         v12_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < TIME_DELAY; i++) begin
            tv_ff[i] <= 1'b0;
         end
      end else begin
         v1_ff        <= accept;
         v5_ff        <= alfa_valid;
         v6_ff        <= v5_ff;
         v10_ff       <= c_valid;
         v11_ff       <= v10_ff;
         v12_ff       <= v11_ff;
         rsp_valid_ff <= v12_ff;
         tv_ff[0]     <= mn_valid;
         for (int i = 1; i < TIME_DELAY; i++) begin
            tv_ff[i] <= tv_ff[i-1];
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_year   = year13_ff;
   assign rsp_month  = month13_ff;
   assign rsp_day    = day13_ff;
   assign rsp_hour   = time13_ff[TIME_BITS-1 -: jd2cd_pkg::HOUR_BITS];
   assign rsp_minute = time13_ff[jd2cd_pkg::SECOND_BITS +: jd2cd_pkg::MINUTE_BITS];
   assign rsp_second = time13_ff[jd2cd_pkg::SECOND_BITS-1:0];

   // date and time halves of the pipeline must stay in step
   assert property (@(posedge clock) disable iff (reset)
      v12_ff == tv_ff[TIME_DELAY-1])
      else $error("top: date and time paths out of step");

   assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("top: accepted beat did not come out");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month != '0 && rsp_month <= 4'd12 && rsp_day != '0
                     && rsp_hour <= 5'd23 && rsp_minute <= 6'd59 && rsp_second <= 6'd59))
      else $error("top: result field out of range");

endmodule

`default_nettype wire

>>> tb/sv/julian_day_to_calendar_date_top_test.sv
// julian_day_to_calendar_date_top_test: self-checking bench for the day-number to
// calendar date and time converter, with randomized start gaps and beat checking.
// Depends on jd2cd_pkg and julian_day_to_calendar_date_top.
`timescale 1ns / 100ps
`default_nettype none

module julian_day_to_calendar_date_top_test;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int TAIL_CYCLES    = 30;

   typedef struct packed {
      logic signed [jd2cd_pkg::YEAR_BITS-1:0] year;
      logic [jd2cd_pkg::MONTH_BITS-1:0]       month;
      logic [jd2cd_pkg::DAY_BITS-1:0]         day;
      logic [jd2cd_pkg::HOUR_BITS-1:0]        hour;
      logic [jd2cd_pkg::MINUTE_BITS-1:0]      minute;
      logic [jd2cd_pkg::SECOND_BITS-1:0]      second;
   } calendar_type;

   typedef struct {
      logic [jd2cd_pkg::DAY_NUMBER_BITS-1:0] jdn;
      logic [jd2cd_pkg::SOD_BITS-1:0]        sod;
      int                                    gap;    // idle cycles after this beat
      bit                                    drain;  // wait for all dates before sending
   } stamp_type;

   logic                                   clock;
   logic                                   reset;
   logic                                   start;
   logic                                   busy;
   logic [jd2cd_pkg::DAY_NUMBER_BITS-1:0]  req_day_number;
   logic [jd2cd_pkg::SOD_BITS-1:0]         req_second_of_day;
   logic                                   rsp_valid;
   logic signed [jd2cd_pkg::YEAR_BITS-1:0] rsp_year;
   logic [jd2cd_pkg::MONTH_BITS-1:0]       rsp_month;
   logic [jd2cd_pkg::DAY_BITS-1:0]         rsp_day;
   logic [jd2cd_pkg::HOUR_BITS-1:0]        rsp_hour;
   logic [jd2cd_pkg::MINUTE_BITS-1:0]      rsp_minute;
   logic [jd2cd_pkg::SECOND_BITS-1:0]      rsp_second;

   stamp_type    stamps_pending[$];
   calendar_type dates_due[$];
   int           beats_sent;
   int           beats_seen;
   int           gap_left;
   int           idle_cycles;
   int           errors;

   julian_day_to_calendar_date_top dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_day_number    (req_day_number),
      .req_second_of_day (req_second_of_day),
      .rsp_valid         (rsp_valid),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day           (rsp_day),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // integer form of the meeus conversion, julian calendar before the switch day
   function automatic calendar_type calendar_of(
         input logic [jd2cd_pkg::DAY_NUMBER_BITS-1:0] jdn,
         input logic [jd2cd_pkg::SOD_BITS-1:0] sod);
      longint unsigned z, a, b, c, d, e, alfa, mon, dom, s;
      longint          yr;
      calendar_type    r;
      z = jdn;
      if (z < 64'd2299161) begin
         a = z;
      end else begin
         alfa = (64'd4 * z - 64'd7468865) / 64'd146097;
         a    = z + 64'd1 + alfa - alfa / 64'd4;
      end
      b   = a + 64'd1524;
      c   = (64'd20 * b - 64'd2442) / 64'd7305;
      d   = (64'd1461 * c) / 64'd4;
      e   = (64'd10000 * (b - d)) / 64'd306001;
      dom = b - d - (64'd306001 * e) / 64'd10000;
      mon = (e < 64'd14) ? (e - 64'd1) : (e - 64'd13);
      yr  = (mon > 64'd2) ? (longint'(c) - 4716) : (longint'(c) - 4715);
      s   = sod;
      if (s >= 64'd86400) s = 64'd86399;  // saturate, never carry into the date
      r.year   = yr[jd2cd_pkg::YEAR_BITS-1:0];
      r.month  = mon[jd2cd_pkg::MONTH_BITS-1:0];
      r.day    = dom[jd2cd_pkg::DAY_BITS-1:0];
      r.hour   = jd2cd_pkg::HOUR_BITS'(s / 64'd3600);
      r.minute = jd2cd_pkg::MINUTE_BITS'((s % 64'd3600) / 64'd60);
      r.second = jd2cd_pkg::SECOND_BITS'(s % 64'd60);
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 45) return 0;
      if (roll < 85) return $urandom_range(3, 1);
      if (roll < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic stamp_type make_stamp(input longint jdn, input longint sod);
      stamp_type st;
      st.jdn   = jd2cd_pkg::DAY_NUMBER_BITS'(jdn);
      st.sod   = jd2cd_pkg::SOD_BITS'(sod);
      st.gap   = pick_gap();
      st.drain = 1'b0;
      return st;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
         errors++;
      end
   endtask

   // driver: one beat per start, holds the beat while busy
   always @(posedge clock) begin
      if (reset) begin
         start      <= 1'b0;
         beats_sent <= 0;
         gap_left   <= 0;
      end else begin
         if (start && !busy) beats_sent <= beats_sent + 1;
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               start    <= 1'b0;
            end else if (stamps_pending.size() > 0 &&
                         !(stamps_pending[0].drain &&
                           (beats_sent + int'(start && !busy) > beats_seen))) begin
               req_day_number    <= stamps_pending[0].jdn;
               req_second_of_day <= stamps_pending[0].sod;
               gap_left          <= stamps_pending[0].gap;
               start             <= 1'b1;
               void'(stamps_pending.pop_front());
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: checks the result beat, then records the beat accepted at this edge
   always @(posedge clock) begin
      calendar_type want;
      if (reset) begin
         beats_seen  <= 0;
         idle_cycles <= 0;
      end else begin
         if (rsp_valid) begin
            beats_seen <= beats_seen + 1;
            if (dates_due.size() == 0) begin
               $display("%0t: unexpected result beat %0d-%0d-%0d %0d:%0d:%0d", $realtime,
                        rsp_year, rsp_month, rsp_day, rsp_hour, rsp_minute, rsp_second);
               errors++;
            end else begin
               want = dates_due.pop_front();
               check_field("year", want.year, rsp_year);
               check_field("month", want.month, rsp_month);
               check_field("day", want.day, rsp_day);
               check_field("hour", want.hour, rsp_hour);
               check_field("minute", want.minute, rsp_minute);
               check_field("second", want.second, rsp_second);
            end
         end
         if (start && !busy) dates_due.push_back(calendar_of(req_day_number,
                                                             req_second_of_day));
         idle_cycles <= (rsp_valid || (start && !busy)) ? 0 : idle_cycles + 1;
      end
   end

   initial begin
      stamp_type st;
      int        roll;
      bit        burst;
      bit        timed_out;
      longint    jdn;
      longint    sod;

      reset             = 1'b1;
      start             = 1'b0;
      req_day_number    = '0;
      req_second_of_day = '0;
      errors            = 0;
      timed_out         = 1'b0;
      burst             = 1'b0;

      // directed: field extremes, calendar switch, leap days, time splits
      stamps_pending.push_back(make_stamp(0, 0));
      stamps_pending.push_back(make_stamp(8388607, 131071));
      stamps_pending.push_back(make_stamp(2299159, 3599));
      stamps_pending.push_back(make_stamp(2299160, 86399));
      stamps_pending.push_back(make_stamp(2299161, 86400));
      stamps_pending.push_back(make_stamp(2299162, 3600));
      stamps_pending.push_back(make_stamp(2451545, 43200));
      stamps_pending.push_back(make_stamp(2451604, 59));
      stamps_pending.push_back(make_stamp(2451605, 60));
      stamps_pending.push_back(make_stamp(2415079, 1));
      stamps_pending.push_back(make_stamp(2415080, 86401));
      stamps_pending.push_back(make_stamp(2268993, 100000));
      stamps_pending.push_back(make_stamp(1721423, 7199));
      stamps_pending.push_back(make_stamp(1721424, 7200));
      stamps_pending.push_back(make_stamp(1721058, 45296));
      stamps_pending.push_back(make_stamp(1, 65535));
      stamps_pending.push_back(make_stamp(4194303, 65536));
      stamps_pending.push_back(make_stamp(4194304, 86340));
      stamps_pending.push_back(make_stamp(2460676, 86280));
      stamps_pending.push_back(make_stamp(2460675, 3660));
      stamps_pending.push_back(make_stamp(5000000, 131070));
      stamps_pending.push_back(make_stamp(8388606, 86399));

      // random: mostly full range, some clustered near the switch and today
      for (int i = 0; i < 1430; i++) begin
         if (i % 50 == 0) burst = ($urandom_range(3) == 0);
         roll = $urandom_range(99);
         if (roll < 60)      jdn = $urandom_range(8388607);
         else if (roll < 80) jdn = $urandom_range(2300161, 2298161);
         else if (roll < 95) jdn = $urandom_range(2480000, 2400000);
         else                jdn = $urandom_range(1723000, 1720000);
         if ($urandom_range(99) < 85) sod = $urandom_range(86399);
         else                         sod = $urandom_range(131071, 86400);
         st = make_stamp(jdn, sod);
         if (burst) st.gap = 0;
         st.drain = (i == 0) || ($urandom_range(299) == 0);
         stamps_pending.push_back(st);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (!(stamps_pending.size() == 0 && !start && beats_seen >= beats_sent)) begin
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            timed_out = 1'b1;
            break;
         end
         @(negedge clock);
      end

      if (timed_out) begin
         $display("%0t: watchdog expired, %0d dates outstanding", $realtime,
                  dates_due.size());
         $display("julian_day_to_calendar_date_top_test: done, errors");
      end else begin
         repeat (TAIL_CYCLES) @(negedge clock);
         if (dates_due.size() != 0) begin
            $display("%0t: %0d expected dates never arrived", $realtime, dates_due.size());
            errors++;
         end
         if (errors == 0) begin
            $display("julian_day_to_calendar_date_top_test: done, clean");
         end else begin
            $display("julian_day_to_calendar_date_top_test: done, errors");
         end
      end
      $finish;
   end

endmodule

`default_nettype wire
